// File: hdl/alpi_pkg.sv
// ----------------------------------------------------------------------------
// alpi_pkg: shared types and codes for the array-based ordered list
// Holds the request and response transaction structs, action codes, status
// codes and the default sizing constants.
// ----------------------------------------------------------------------------
package alpi_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Action codes carried in the request
  localparam logic [3:0] ACT_READ     = 4'd0;
  localparam logic [3:0] ACT_WRITE    = 4'd1;
  localparam logic [3:0] ACT_INS_HEAD = 4'd2;
  localparam logic [3:0] ACT_INS_TAIL = 4'd3;
  localparam logic [3:0] ACT_INS_AT   = 4'd4;
  localparam logic [3:0] ACT_REM_HEAD = 4'd5;
  localparam logic [3:0] ACT_REM_TAIL = 4'd6;
  localparam logic [3:0] ACT_REM_AT   = 4'd7;
  localparam logic [3:0] ACT_CLEAR    = 4'd8;

  // Status codes returned in the response
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [6:0]  position;
    logic [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } rsp_t;

  // Finished response handed from the sequencer to the output stage
  typedef struct packed {
    logic done;
    rsp_t rsp;
  } done_t;

endpackage

// File: hdl/alpi_ram.sv
// ----------------------------------------------------------------------------
// alpi_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module alpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/alpi_ctrl.sv
// ----------------------------------------------------------------------------
// alpi_ctrl: request decode and shift sequencer
// Decodes a request against the entry count, then streams reads and
// write-backs through the RAM to open or close a gap, one entry per cycle.
// ----------------------------------------------------------------------------
module alpi_ctrl #(
  parameter int DEPTH      = alpi_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = alpi_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  alpi_pkg::req_t           in_data,
  output alpi_pkg::done_t          done_o,
  input  logic                     ack_i,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_WIDTH-1:0]    ram_rdata
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = (CW > 7) ? CW : 7;
  localparam int WIDE = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]         rd_left_r, rd_left_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic                  capture_r, capture_nxt;
  logic                  up_r, up_nxt;
  logic                  fin_r, fin_nxt;
  logic [AW-1:0]         fin_addr_r, fin_addr_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [31:0]           res_val_r, res_val_nxt;
  logic [1:0]            status_r, status_nxt;

  logic                  accept;
  logic [PW-1:0]         pos_w, cnt_w, pos_m1_w;
  logic                  pos_ok, full, empty;
  logic [AW-1:0]         pos_a, cnt_a, cm1_a;
  logic [CW-1:0]         span;
  logic [WIDE-1:0]       in_wide, rd_wide;
  logic                  issue;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign pos_w    = PW'(in_data.position);
  assign cnt_w    = PW'(count_r);
  assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_m1_w = pos_w - PW'(1);
  assign pos_a    = pos_m1_w[AW-1:0];
  assign cnt_a    = count_r[AW-1:0];
  assign cm1_a    = cnt_a - AW'(1);
  assign span     = count_r - CW'(pos_a);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_wide  = WIDE'(in_data.item_value);
  assign rd_wide  = WIDE'(ram_rdata);
  assign issue    = (state_r == S_RUN) && (rd_left_r != '0);

  assign ram_raddr = rd_addr_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    rd_addr_nxt  = rd_addr_r;
    rd_left_nxt  = rd_left_r;
    pend_nxt     = 1'b0;
    src_nxt      = rd_addr_r;
    capture_nxt  = capture_r;
    up_nxt       = up_r;
    fin_nxt      = fin_r;
    fin_addr_nxt = fin_addr_r;
    val_nxt      = val_r;
    res_val_nxt  = res_val_r;
    status_nxt   = status_r;
    ram_we       = 1'b0;
    ram_waddr    = fin_addr_r;
    ram_wdata    = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_RUN;
          rd_left_nxt = '0;
          capture_nxt = 1'b0;
          up_nxt      = 1'b0;
          fin_nxt     = 1'b0;
          val_nxt     = in_wide[DATA_WIDTH-1:0];
          res_val_nxt = '0;
          status_nxt  = alpi_pkg::ST_OK;
          unique case (in_data.action)
            alpi_pkg::ACT_READ: begin
              if (pos_ok) begin
                rd_addr_nxt = pos_a;
                rd_left_nxt = CW'(1);
                capture_nxt = 1'b1;
              end else begin
                status_nxt = alpi_pkg::ST_BADPOS;
              end
            end
            alpi_pkg::ACT_WRITE: begin
              if (pos_ok) begin
                fin_nxt      = 1'b1;
                fin_addr_nxt = pos_a;
              end else begin
                status_nxt = alpi_pkg::ST_BADPOS;
              end
            end
            alpi_pkg::ACT_INS_HEAD: begin
              if (full) begin
                status_nxt = alpi_pkg::ST_FULL;
              end else begin
                rd_addr_nxt  = cm1_a;
                rd_left_nxt  = count_r;
                up_nxt       = 1'b1;
                fin_nxt      = 1'b1;
                fin_addr_nxt = '0;
                count_nxt    = count_r + CW'(1);
              end
            end
            alpi_pkg::ACT_INS_TAIL: begin
              if (full) begin
                status_nxt = alpi_pkg::ST_FULL;
              end else begin
                fin_nxt      = 1'b1;
                fin_addr_nxt = cnt_a;
                count_nxt    = count_r + CW'(1);
              end
            end
            alpi_pkg::ACT_INS_AT: begin
              if (full) begin
                status_nxt = alpi_pkg::ST_FULL;
              end else if (!pos_ok) begin
                status_nxt = alpi_pkg::ST_BADPOS;
              end else begin
                rd_addr_nxt  = cm1_a;
                rd_left_nxt  = span;
                up_nxt       = 1'b1;
                fin_nxt      = 1'b1;
                fin_addr_nxt = pos_a;
                count_nxt    = count_r + CW'(1);
              end
            end
            alpi_pkg::ACT_REM_HEAD: begin
              if (empty) begin
                status_nxt = alpi_pkg::ST_EMPTY;
              end else begin
                rd_addr_nxt = '0;
                rd_left_nxt = count_r;
                capture_nxt = 1'b1;
                count_nxt   = count_r - CW'(1);
              end
            end
            alpi_pkg::ACT_REM_TAIL: begin
              if (empty) begin
                status_nxt = alpi_pkg::ST_EMPTY;
              end else begin
                rd_addr_nxt = cm1_a;
                rd_left_nxt = CW'(1);
                capture_nxt = 1'b1;
                count_nxt   = count_r - CW'(1);
              end
            end
            alpi_pkg::ACT_REM_AT: begin
              if (empty) begin
                status_nxt = alpi_pkg::ST_EMPTY;
              end else if (!pos_ok) begin
                status_nxt = alpi_pkg::ST_BADPOS;
              end else begin
                rd_addr_nxt = pos_a;
                rd_left_nxt = span;
                capture_nxt = 1'b1;
                count_nxt   = count_r - CW'(1);
              end
            end
            alpi_pkg::ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        // advance the read stream
        if (issue) begin
          rd_left_nxt = rd_left_r - CW'(1);
          rd_addr_nxt = up_r ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
          pend_nxt    = 1'b1;
        end
        // retire the read issued last cycle
        if (pend_r) begin
          if (capture_r) begin
            res_val_nxt = rd_wide[31:0];
            capture_nxt = 1'b0;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = up_r ? src_r + AW'(1) : src_r - AW'(1);
            ram_wdata = ram_rdata;
          end
        end
        if (!issue && !pend_r) begin
          ram_we    = fin_r;
          state_nxt = S_WAIT;
        end
      end

      S_WAIT: begin
        if (ack_i) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    rd_left_r  <= rd_left_nxt;
    src_r      <= src_nxt;
    capture_r  <= capture_nxt;
    up_r       <= up_nxt;
    fin_r      <= fin_nxt;
    fin_addr_r <= fin_addr_nxt;
    val_r      <= val_nxt;
    res_val_r  <= res_val_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    done_o                  = '0;
    done_o.done             = (state_r == S_WAIT);
    done_o.rsp.result_value = res_val_r;
    done_o.rsp.status       = status_r;
    done_o.rsp.entry_count  = 7'(count_r);
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_we_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_RUN))
    else $error("RAM write outside the shift sequence");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (done_o.done && !ack_i) |=> (done_o.done && $stable(done_o.rsp)))
    else $error("finished response changed before hand-off");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !in_ready)
    else $error("request accepted while a read is in flight");
`endif

endmodule

// File: hdl/array_list_position_insert_remove.sv
// Flow: a request is decoded on acceptance, any entries that it reads are
//   streamed through the RAM one per cycle, and the response then waits in
//   the sequencer until the output register takes it. Only one transaction
//   is in flight at a time; a new request is accepted only after that hand-off.
// Reset: synchronous active-low rst_n empties the list; entry storage is not
//   cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
// array_list_position_insert_remove: ordered list in a RAM with a count
// Read, overwrite, insert and remove by position, head or tail, and clear.
// Rejected requests leave the list unchanged and report a status code.
// ----------------------------------------------------------------------------
module array_list_position_insert_remove #(
  parameter int DEPTH      = alpi_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = alpi_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  alpi_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output alpi_pkg::rsp_t out_data
);

  localparam int AW = $clog2(DEPTH);

  alpi_pkg::done_t       done;
  logic                  ack;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  out_valid_r, out_valid_nxt;
  alpi_pkg::rsp_t        out_data_r, out_data_nxt;

  // Entry storage: one write and one registered read per cycle
  alpi_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode and shift sequencer; owns the entry count
  alpi_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .done_o    (done),
    .ack_i     (ack),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: take a finished response when the slot is empty or
  // draining this cycle, so the sequencer can return to idle and accept the
  // next transaction while this one still waits downstream.
  assign ack = done.done && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (ack) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = done.rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for array_list_position_insert_remove
// Drives list requests over a valid/ready channel and keeps a shadow copy of
// the list. Each accepted request produces the response that the shadow list
// gives. Every response is checked field by field against the oldest one that
// is still owed. Both channels idle at random, and the receiver also holds
// off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIST_DEPTH  = alpi_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;       // long receiver hold-off
  localparam int DRAIN_WAIT  = 80;        // extra wait after the last owed response
  localparam int CYCLE_LIMIT = 1000000;   // slowest correct run is well below

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  alpi_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  alpi_pkg::rsp_t out_data;

  // Shadow list that tracks the block's contents
  logic [31:0] shadow_entries [LIST_DEPTH];
  int          shadow_len = 0;

  alpi_pkg::rsp_t owed_responses [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Idling control: steady turns off random idling on both sides;
  // toggling hold_req starts one long receiver hold-off.
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  array_list_position_insert_remove u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow list model
  // --------------------------------------------------------------------------

  // Shift entries at and above the slot up by one to make room
  function automatic void open_slot(int at);
    for (int i = shadow_len; i > at; i--) shadow_entries[i] = shadow_entries[i - 1];
  endfunction

  // Take the entry at the slot out and shift the later ones down
  function automatic logic [31:0] close_slot(int at);
    logic [31:0] taken;
    taken = shadow_entries[at];
    for (int i = at; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_len--;
    return taken;
  endfunction

  // Apply one request to the shadow list and return the response it owes
  function automatic alpi_pkg::rsp_t list_apply(alpi_pkg::req_t r);
    alpi_pkg::rsp_t rsp;
    int   p;
    bit   in_range;
    rsp = '0;
    rsp.status = alpi_pkg::ST_OK;
    p = r.position;
    in_range = (p >= 1) && (p <= shadow_len);
    case (r.action)
      alpi_pkg::ACT_READ: begin
        if (in_range) rsp.result_value = shadow_entries[p - 1];
        else rsp.status = alpi_pkg::ST_BADPOS;
      end
      alpi_pkg::ACT_WRITE: begin
        if (in_range) shadow_entries[p - 1] = r.item_value;
        else rsp.status = alpi_pkg::ST_BADPOS;
      end
      alpi_pkg::ACT_INS_HEAD: begin
        if (shadow_len >= LIST_DEPTH) begin
          rsp.status = alpi_pkg::ST_FULL;
        end else begin
          open_slot(0);
          shadow_entries[0] = r.item_value;
          shadow_len++;
        end
      end
      alpi_pkg::ACT_INS_TAIL: begin
        if (shadow_len >= LIST_DEPTH) begin
          rsp.status = alpi_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_len] = r.item_value;
          shadow_len++;
        end
      end
      alpi_pkg::ACT_INS_AT: begin
        // full wins over a bad position
        if (shadow_len >= LIST_DEPTH) begin
          rsp.status = alpi_pkg::ST_FULL;
        end else if (!in_range) begin
          rsp.status = alpi_pkg::ST_BADPOS;
        end else begin
          open_slot(p - 1);
          shadow_entries[p - 1] = r.item_value;
          shadow_len++;
        end
      end
      alpi_pkg::ACT_REM_HEAD: begin
        if (shadow_len == 0) rsp.status = alpi_pkg::ST_EMPTY;
        else rsp.result_value = close_slot(0);
      end
      alpi_pkg::ACT_REM_TAIL: begin
        if (shadow_len == 0) begin
          rsp.status = alpi_pkg::ST_EMPTY;
        end else begin
          shadow_len--;
          rsp.result_value = shadow_entries[shadow_len];
        end
      end
      alpi_pkg::ACT_REM_AT: begin
        // empty wins over a bad position
        if (shadow_len == 0) rsp.status = alpi_pkg::ST_EMPTY;
        else if (!in_range) rsp.status = alpi_pkg::ST_BADPOS;
        else rsp.result_value = close_slot(p - 1);
      end
      alpi_pkg::ACT_CLEAR: begin
        shadow_len = 0;   // entries stay, only the count drops
      end
      default: begin
        // unused codes: no change, plain OK response
      end
    endcase
    rsp.entry_count = 7'(shadow_len);
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request generation
  // --------------------------------------------------------------------------

  function automatic alpi_pkg::req_t make_req(logic [3:0] act, logic [6:0] pos,
                                              logic [31:0] val);
    alpi_pkg::req_t r;
    r.action = act;
    r.position = pos;
    r.item_value = val;
    return r;
  endfunction

  // Random request; grow leans toward inserts, otherwise toward removes.
  // Most positions land inside the list, the rest anywhere in 0..127.
  function automatic alpi_pkg::req_t pick_request(bit grow);
    alpi_pkg::req_t r;
    int   roll;
    r.item_value = $urandom;
    r.position = 7'($urandom_range(0, 127));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      r.action = 4'($urandom_range(9, 15));
    end else if (roll < 4) begin
      r.action = alpi_pkg::ACT_CLEAR;
    end else if (roll < 19) begin
      r.action = $urandom_range(0, 1) ? alpi_pkg::ACT_READ : alpi_pkg::ACT_WRITE;
    end else if (roll < (grow ? 74 : 44)) begin
      case ($urandom_range(0, 2))
        0:       r.action = alpi_pkg::ACT_INS_HEAD;
        1:       r.action = alpi_pkg::ACT_INS_TAIL;
        default: r.action = alpi_pkg::ACT_INS_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       r.action = alpi_pkg::ACT_REM_HEAD;
        1:       r.action = alpi_pkg::ACT_REM_TAIL;
        default: r.action = alpi_pkg::ACT_REM_AT;
      endcase
    end
    if (shadow_len > 0 && $urandom_range(0, 99) < 85)
      r.position = 7'($urandom_range(1, shadow_len));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offer one request, hold it until accepted, then log the owed response.
  // Valid stays high after acceptance so back-to-back requests need no gap.
  task automatic send_request(input alpi_pkg::req_t r);
    if (!steady) begin
      while ($urandom_range(0, 99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    owed_responses.push_back(list_apply(r));
  endtask

  // Drop valid and wait until every owed response has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_responses.size() != 0);
  endtask

  // Receiver: random backpressure, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_ready <= 1'b0;
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 32);
    end
  end

  // Response checker: compare each transaction with the oldest owed one
  always @(posedge clk) begin
    alpi_pkg::rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = owed_responses.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, out_data.result_value);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   want.entry_count, out_data.entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reads, writes, positional insert and removes on an empty list, plus unused action codes
  task automatic test_empty_list();
    send_request(make_req(alpi_pkg::ACT_READ,     7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_READ,     7'd1,   32'h0));
    send_request(make_req(alpi_pkg::ACT_WRITE,    7'd1,   32'hFFFF_FFFF));
    send_request(make_req(alpi_pkg::ACT_INS_AT,   7'd1,   32'h1234_5678));  // bad position
    send_request(make_req(alpi_pkg::ACT_REM_HEAD, 7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_TAIL, 7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_AT,   7'd0,   32'h0));          // empty first
    send_request(make_req(4'd15,                  7'd127, 32'hFFFF_FFFF));
    send_request(make_req(4'd9,                   7'd1,   32'h0));
  endtask

  // Each action on a small list, with data and position extremes
  task automatic test_basic_actions();
    send_request(make_req(alpi_pkg::ACT_INS_TAIL, 7'd0,   32'hFFFF_FFFF));
    send_request(make_req(alpi_pkg::ACT_INS_HEAD, 7'd0,   32'h0000_0000));
    send_request(make_req(alpi_pkg::ACT_INS_AT,   7'd2,   32'hA5A5_5A5A));
    send_request(make_req(alpi_pkg::ACT_INS_AT,   7'd3,   32'h0F0F_F0F0));  // before the tail
    send_request(make_req(alpi_pkg::ACT_WRITE,    7'd1,   32'h8000_0001));
    send_request(make_req(alpi_pkg::ACT_READ,     7'd1,   32'h0));
    send_request(make_req(alpi_pkg::ACT_READ,     7'd4,   32'h0));
    send_request(make_req(alpi_pkg::ACT_READ,     7'd5,   32'h0));          // one past the end
    send_request(make_req(alpi_pkg::ACT_READ,     7'd127, 32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_AT,   7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_AT,   7'd2,   32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_HEAD, 7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_TAIL, 7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_CLEAR,    7'd0,   32'h0));
    send_request(make_req(alpi_pkg::ACT_READ,     7'd1,   32'h0));  // cleared entries hidden
  endtask

  // Fill to capacity with no idling, hit every full case, then drain
  task automatic test_full_list();
    alpi_pkg::req_t r;
    steady <= 1'b1;
    while (shadow_len < LIST_DEPTH) begin
      r.item_value = $urandom;
      r.position = (shadow_len > 0) ? 7'($urandom_range(1, shadow_len)) : 7'd0;
      case ($urandom_range(0, 2))
        0:       r.action = alpi_pkg::ACT_INS_HEAD;
        1:       r.action = alpi_pkg::ACT_INS_TAIL;
        default: r.action = alpi_pkg::ACT_INS_AT;
      endcase
      send_request(r);
    end
    send_request(make_req(alpi_pkg::ACT_INS_HEAD, 7'd1, 32'hDEAD_BEEF));
    send_request(make_req(alpi_pkg::ACT_INS_TAIL, 7'd1, 32'hDEAD_BEEF));
    send_request(make_req(alpi_pkg::ACT_INS_AT,   7'd1, 32'hDEAD_BEEF));
    send_request(make_req(alpi_pkg::ACT_INS_AT,   7'd0, 32'hDEAD_BEEF));  // full beats bad position
    send_request(make_req(alpi_pkg::ACT_READ,     7'(LIST_DEPTH),     32'h0));
    send_request(make_req(alpi_pkg::ACT_WRITE,    7'(LIST_DEPTH),     32'hC001_D00D));
    send_request(make_req(alpi_pkg::ACT_READ,     7'(LIST_DEPTH + 1), 32'h0));
    send_request(make_req(alpi_pkg::ACT_REM_AT,   7'd1, 32'h0));          // longest close
    send_request(make_req(alpi_pkg::ACT_INS_AT,   7'd1, 32'h7777_7777));  // longest open
    steady <= 1'b0;
    while (shadow_len > 0) begin
      r = pick_request(1'b0);
      if (r.action == alpi_pkg::ACT_CLEAR) r.action = alpi_pkg::ACT_REM_AT;
      send_request(r);
    end
  endtask

  // Hold the receiver off while requests keep coming, so the block stalls
  task automatic test_receiver_hold();
    hold_req <= ~hold_req;
    repeat (16) send_request(pick_request(1'b1));
  endtask

  // Short bursts, each followed by a full drain on the sending side
  task automatic test_sender_pause();
    repeat (4) begin
      repeat (10) send_request(pick_request($urandom_range(0, 1)));
      wait_for_results();
    end
  endtask

  // Long random mix in alternating grow and shrink phases
  task automatic test_random_mix(input int total);
    int  sent;
    int  phase_len;
    bit  grow;
    sent = 0;
    grow = 1'b1;
    while (sent < total) begin
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        send_request(pick_request(grow));
        sent++;
      end
      grow = !grow;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_basic_actions();
    test_full_list();
    test_receiver_hold();
    test_sender_pause();
    test_random_mix(1050);

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
